// ----- hw/rtl/eihx_pkg.sv -----
// ---------------------------------------------------------------------------
// eihx_pkg: shared types and constants for the header extractor
// Transaction payload structs, parse phases and the protocol constants.
// ---------------------------------------------------------------------------
package eihx_pkg;

    // ethernet / llc constants
    localparam logic [15:0] TypeVlan = 16'h8100;
    localparam logic [15:0] TypeIpv4 = 16'h0800;
    localparam logic [15:0] LenMax   = 16'h05DC;
    localparam logic [7:0]  SapSnap  = 8'hAA;

    // header byte offsets of interest
    localparam logic [4:0] MacTypeHi  = 5'd12;
    localparam logic [4:0] MacLast    = 5'd13;
    localparam logic [4:0] VlanTypeHi = 5'd2;
    localparam logic [4:0] VlanLast   = 5'd3;
    localparam logic [4:0] SnapSsap   = 5'd1;
    localparam logic [4:0] SnapOuiLo  = 5'd3;
    localparam logic [4:0] SnapOuiHi  = 5'd5;
    localparam logic [4:0] SnapTypeHi = 5'd6;
    localparam logic [4:0] SnapLast   = 5'd7;
    localparam logic [4:0] IpProto    = 5'd9;
    localparam logic [4:0] IpSrcLo    = 5'd12;
    localparam logic [4:0] IpSrcHi    = 5'd15;
    localparam logic [4:0] IpDstLo    = 5'd16;
    localparam logic [4:0] IpLast     = 5'd19;

    // default depth of the result queue
    localparam int QueueDepth = 4;

    // parse phase, one-hot
    typedef enum logic [4:0] {
        PH_MAC  = 5'b00001,
        PH_VLAN = 5'b00010,
        PH_SNAP = 5'b00100,
        PH_IP   = 5'b01000,
        PH_SKIP = 5'b10000
    } phase_t;

    // input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  ip_proto;
    } result_t;

endpackage

// ----- hw/rtl/eihx_parser.sv -----
// ---------------------------------------------------------------------------
// eihx_parser: byte-serial frame header parser (front end)
// Walks the MAC, optional VLAN, LLC/SNAP and IPv4 headers one accepted
// byte per cycle and emits an address record on the 20th IPv4 header byte.
// ---------------------------------------------------------------------------
module eihx_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  eihx_pkg::in_item_t item,
    output logic               res_valid,
    output eihx_pkg::result_t  res
);

    eihx_pkg::phase_t phase_reg, phase_next;
    logic [4:0]       offset_reg, offset_next;
    logic [15:0]      type_reg, type_next;
    logic             snap_reg, snap_next;
    logic [31:0]      src_reg, src_next;
    logic [31:0]      dst_reg, dst_next;
    logic [7:0]       proto_reg, proto_next;
    logic [15:0]      type_shift;
    logic [7:0]       b;

    // next phase from a completed type word
    function automatic eihx_pkg::phase_t dispatch(input logic [15:0] tw,
                                                  input logic allow_vlan);
        eihx_pkg::phase_t ph;
        if (allow_vlan && tw == eihx_pkg::TypeVlan)
            ph = eihx_pkg::PH_VLAN;
        else if (tw <= eihx_pkg::LenMax)
            ph = eihx_pkg::PH_SNAP;
        else if (tw == eihx_pkg::TypeIpv4)
            ph = eihx_pkg::PH_IP;
        else
            ph = eihx_pkg::PH_SKIP;
        return ph;
    endfunction

    assign b          = item.data_byte;
    assign type_shift = {type_reg[7:0], b};

    // per-byte parse step
    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        type_next   = type_reg;
        snap_next   = snap_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        proto_next  = proto_reg;
        res_valid   = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                eihx_pkg::PH_MAC:
                begin
                    if (offset_reg >= eihx_pkg::MacTypeHi)
                        type_next = type_shift;
                    if (offset_reg == eihx_pkg::MacLast)
                    begin
                        offset_next = '0;
                        phase_next  = dispatch(type_shift, 1'b1);
                        if (phase_next == eihx_pkg::PH_SNAP)
                            snap_next = 1'b1;
                    end
                    else
                        offset_next = 5'(offset_reg + 5'd1);
                end
                eihx_pkg::PH_VLAN:
                begin
                    if (offset_reg >= eihx_pkg::VlanTypeHi)
                        type_next = type_shift;
                    if (offset_reg == eihx_pkg::VlanLast)
                    begin
                        offset_next = '0;
                        phase_next  = dispatch(type_shift, 1'b0);
                        if (phase_next == eihx_pkg::PH_SNAP)
                            snap_next = 1'b1;
                    end
                    else
                        offset_next = 5'(offset_reg + 5'd1);
                end
                eihx_pkg::PH_SNAP:
                begin
                    if (offset_reg <= eihx_pkg::SnapSsap && b != eihx_pkg::SapSnap)
                        snap_next = 1'b0;
                    if (offset_reg >= eihx_pkg::SnapOuiLo &&
                        offset_reg <= eihx_pkg::SnapOuiHi && b != 8'h00)
                        snap_next = 1'b0;
                    if (offset_reg >= eihx_pkg::SnapTypeHi)
                        type_next = type_shift;
                    if (offset_reg == eihx_pkg::SnapLast)
                    begin
                        offset_next = '0;
                        phase_next  = (snap_reg && type_shift == eihx_pkg::TypeIpv4) ?
                                      eihx_pkg::PH_IP : eihx_pkg::PH_SKIP;
                    end
                    else
                        offset_next = 5'(offset_reg + 5'd1);
                end
                eihx_pkg::PH_IP:
                begin
                    if (offset_reg == eihx_pkg::IpProto)
                        proto_next = b;
                    else if (offset_reg >= eihx_pkg::IpSrcLo &&
                             offset_reg <= eihx_pkg::IpSrcHi)
                        src_next = {src_reg[23:0], b};
                    else if (offset_reg >= eihx_pkg::IpDstLo)
                        dst_next = {dst_reg[23:0], b};
                    if (offset_reg == eihx_pkg::IpLast)
                    begin
                        res_valid   = 1'b1;
                        offset_next = '0;
                        phase_next  = eihx_pkg::PH_SKIP;
                    end
                    else
                        offset_next = 5'(offset_reg + 5'd1);
                end
                default:
                begin
                end
            endcase
            // frame end restarts the parse
            if (item.frame_end)
            begin
                phase_next  = eihx_pkg::PH_MAC;
                offset_next = '0;
                type_next   = '0;
                snap_next   = 1'b1;
            end
        end
    end

    // result record, last destination byte taken straight from the input
    assign res.src_addr = src_reg;
    assign res.dst_addr = {dst_reg[23:0], b};
    assign res.ip_proto = proto_reg;

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= eihx_pkg::PH_MAC;
            offset_reg <= '0;
            type_reg   <= '0;
            snap_reg   <= 1'b1;
            src_reg    <= '0;
            dst_reg    <= '0;
            proto_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            type_reg   <= type_next;
            snap_reg   <= snap_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            proto_reg  <= proto_next;
        end
    end

    // checks
    a_res_at_ip_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (phase_reg == eihx_pkg::PH_IP && offset_reg == eihx_pkg::IpLast))
        else $error("result outside the last ipv4 header byte");

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parse phase not one-hot");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.frame_end) |=> (phase_reg == eihx_pkg::PH_MAC && offset_reg == 5'd0))
        else $error("frame end did not restart the parser");

    a_mac_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == eihx_pkg::PH_MAC) |-> (offset_reg <= eihx_pkg::MacLast))
        else $error("mac offset out of range");

endmodule

// ----- hw/rtl/eihx_queue.sv -----
// ---------------------------------------------------------------------------
// eihx_queue: result queue (back end)
// Holds finished address records until the consumer pops them, so the
// parser keeps taking bytes while a result waits and the queue has room.
// ---------------------------------------------------------------------------
module eihx_queue #(
    parameter int Depth = eihx_pkg::QueueDepth
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  eihx_pkg::result_t wr_data,
    input  logic              rd_en,
    output eihx_pkg::result_t rd_data,
    output logic              full,
    output logic              empty
);

    localparam int AW = $clog2(Depth);
    localparam int CW = $clog2(Depth + 1);

    eihx_pkg::result_t mem_reg [Depth];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == CW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        if (do_wr && !do_rd)
            count_next = CW'(count_reg + 1'b1);
        else if (do_rd && !do_wr)
            count_next = CW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(Depth))
        else $error("queue occupancy above depth");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("result written into a full queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("occupancy did not grow on write");

endmodule

// ----- hw/rtl/ethernet_ipv4_header_extractor.sv -----
// ---------------------------------------------------------------------------
// ethernet_ipv4_header_extractor: ethernet / ipv4 address extractor
// Parses frames byte by byte and queues source, destination and protocol
// of each ipv4 frame that passes the header checks.
// ---------------------------------------------------------------------------
// result: a result is visible (empty low) in the cycle after the 20th ipv4
//   header byte is accepted
// throughput: one byte per cycle while full is low; full rises only while
//   the result queue (QueueDepth entries) holds that many unread results
// reset: rst_n low clears the parser to the mac header phase and empties the
//   queue; no clearing pass, bytes are taken as soon as rst_n is released
module ethernet_ipv4_header_extractor #(
    parameter int QueueDepth = eihx_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  eihx_pkg::in_item_t item,
    output logic               empty,
    input  logic               pop,
    output eihx_pkg::result_t  result
);

    logic              accept;
    logic              res_valid;
    eihx_pkg::result_t res;

    assign accept = push && !full;

    // front end: header parser
    eihx_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // back end: result queue
    eihx_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (result),
        .full    (full),
        .empty   (empty)
    );

endmodule
